FILE: src/key_change_event_queue_top_assert.svh
// Assertion macros for the key change event queue.
// Used by key_change_event_queue_top; expects clk and rst in scope.
`ifndef KEY_CHANGE_EVENT_QUEUE_TOP_ASSERT_SVH
`define KEY_CHANGE_EVENT_QUEUE_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define KCEQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kceq invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define KCEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kceq sequence violated");

`endif

FILE: src/kceq_pkg.sv
// Shared types and constants for the key change event queue.
// No dependencies.
package kceq_pkg;

  localparam int KEY_IN_W = 16;  // width of the key_bits field
  localparam int KEY_W    = 4;   // width of a stored key index
  localparam int ENTRY_W  = KEY_W + 1;
  localparam int CMD_W    = 2;
  localparam int TALLY_W  = 5;
  localparam int QCNT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_POP     = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // One step of the bit-serial key scan.
  typedef struct packed {
    logic               push;
    logic               last;
    logic [ENTRY_W-1:0] entry;
  } scan_evt_t;

  // Requests into the ring.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               clear;
    logic [ENTRY_W-1:0] entry;
  } ring_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

FILE: src/kceq_in_if.sv
// Input channel of the key change event queue: command and key levels.
// Depends on kceq_pkg.
interface kceq_in_if import kceq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_IN_W-1:0] key_bits;

  modport source (output valid, command, key_bits, input ready);
  modport sink   (input valid, command, key_bits, output ready);
endinterface

FILE: src/kceq_out_if.sv
// Result channel of the key change event queue.
// Depends on kceq_pkg.
interface kceq_out_if import kceq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               event_valid;
  logic [KEY_W-1:0]   event_key;
  logic               event_pressed;
  logic [TALLY_W-1:0] events_added;
  logic [TALLY_W-1:0] events_dropped;
  logic [QCNT_W-1:0]  queued_count;

  modport source (output valid, event_valid, event_key, event_pressed, events_added,
                  events_dropped, queued_count, input ready);
  modport sink   (input valid, event_valid, event_key, event_pressed, events_added,
                  events_dropped, queued_count, output ready);
endinterface

FILE: src/kceq_scan.sv
// Bit-serial change scanner: shifts the changed-key mask one bit per cycle.
// Depends on kceq_pkg.
module kceq_scan import kceq_pkg::*; #(
  parameter int KEY_LIMIT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [KEY_LIMIT-1:0] keys,
  input  logic [KEY_LIMIT-1:0] last_keys,
  output scan_evt_t            evt
);

  localparam int IDX_W = (KEY_LIMIT > 1) ? $clog2(KEY_LIMIT) : 1;

  logic                 busy;
  logic [IDX_W-1:0]     idx;
  logic [KEY_LIMIT-1:0] changed_sr;
  logic [KEY_LIMIT-1:0] level_sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy       <= 1'b1;
      idx        <= '0;
      changed_sr <= keys ^ last_keys;
      level_sr   <= keys;
    end else if (busy) begin
      changed_sr <= changed_sr >> 1;
      level_sr   <= level_sr >> 1;
      idx        <= IDX_W'(idx + 1'b1);
      if (evt.last) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    evt.push  = busy && changed_sr[0];
    evt.last  = busy && (idx == IDX_W'(KEY_LIMIT - 1));
    evt.entry = {level_sr[0], KEY_W'(idx)};
  end

endmodule

FILE: src/kceq_ring.sv
// Event ring: memory, head and tail pointers, fill count; drops oldest when full.
// Depends on kceq_pkg.
module kceq_ring import kceq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ring_cmd_t                          cmd,
  output ring_stat_t                         stat,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
  output logic [ENTRY_W-1:0]                 rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;

  assign head_inc   = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(head + 1'b1);
  assign tail_inc   = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(tail + 1'b1);
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.entry;
    end
    if (cmd.pop) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      tail <= tail_inc;
      // full ring: oldest event is overwritten, count stays
      if (stat.full) begin
        head <= head_inc;
      end else begin
        count <= CNT_W'(count + 1'b1);
      end
    end else if (cmd.pop) begin
      head  <= head_inc;
      count <= CNT_W'(count - 1'b1);
    end
  end

endmodule

FILE: src/key_change_event_queue_top.sv
// Key change event queue. One item in flight; the result register frees the input side.
// Flow: a sample goes from IDLE to SCAN (one key per cycle through the change shift
// register), then to FIN, which loads the result register once it is free; pop,
// restart and no-op go from IDLE straight to FIN. A new item is taken only in IDLE.
// Reset: synchronous rst clears head, tail, count, last sample and the handshake state;
// ring memory is not cleared (entries outside the valid window are never read).
`include "key_change_event_queue_top_assert.svh"

module key_change_event_queue_top import kceq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int KEY_COUNT   = 16
) (
  input  logic       clk,
  input  logic       rst,
  kceq_in_if.sink    req,
  kceq_out_if.source rsp
);

  localparam int KEY_LIMIT = (KEY_COUNT < KEY_IN_W) ? KEY_COUNT : KEY_IN_W;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

  state_t               st;
  logic [KEY_LIMIT-1:0] last_keys;
  logic [KEY_LIMIT-1:0] keys;
  logic [TALLY_W-1:0]   added;
  logic [TALLY_W-1:0]   dropped;
  logic                 pop_hit;
  logic                 out_valid;
  logic                 accept;
  logic                 out_free;
  cmd_t                 cmd;

  logic               ev_valid_q;
  logic [KEY_W-1:0]   ev_key_q;
  logic               ev_pressed_q;
  logic [TALLY_W-1:0] added_q;
  logic [TALLY_W-1:0] dropped_q;
  logic [QCNT_W-1:0]  qcount_q;

  scan_evt_t          scan_evt;
  ring_cmd_t          ring_cmd;
  ring_stat_t         ring_stat;
  logic [CNT_W-1:0]   ring_count;
  logic [ENTRY_W-1:0] ring_rd;

  assign keys      = req.key_bits[KEY_LIMIT-1:0];
  assign cmd       = cmd_t'(req.command);
  assign req.ready = (st == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  kceq_scan #(.KEY_LIMIT(KEY_LIMIT)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (cmd == CMD_SAMPLE)),
    .keys      (keys),
    .last_keys (last_keys),
    .evt       (scan_evt)
  );

  always_comb begin
    ring_cmd.push  = (st == ST_SCAN) && scan_evt.push;
    ring_cmd.pop   = accept && (cmd == CMD_POP) && !ring_stat.empty;
    ring_cmd.clear = accept && (cmd == CMD_RESTART);
    ring_cmd.entry = scan_evt.entry;
  end

  kceq_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ring_cmd),
    .stat    (ring_stat),
    .count   (ring_count),
    .rd_data (ring_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      last_keys <= '0;
      added     <= '0;
      dropped   <= '0;
      pop_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((st == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            added   <= '0;
            dropped <= '0;
            pop_hit <= (cmd == CMD_POP) && !ring_stat.empty;
            // unused code falls through to the result with no operation
            st      <= (cmd == CMD_SAMPLE) ? ST_SCAN : ST_FIN;
            if ((cmd == CMD_SAMPLE) || (cmd == CMD_RESTART)) begin
              last_keys <= keys;
            end
          end
        end
        ST_SCAN: begin
          if (scan_evt.push) begin
            added <= TALLY_W'(added + 1'b1);
            if (ring_stat.full) begin
              dropped <= TALLY_W'(dropped + 1'b1);
            end
          end
          if (scan_evt.last) begin
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((st == ST_FIN) && out_free) begin
      ev_valid_q   <= pop_hit;
      ev_key_q     <= pop_hit ? ring_rd[KEY_W-1:0] : '0;
      ev_pressed_q <= pop_hit && ring_rd[KEY_W];
      added_q      <= added;
      dropped_q    <= dropped;
      qcount_q     <= QCNT_W'(ring_count);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.event_valid    = ev_valid_q;
  assign rsp.event_key      = ev_key_q;
  assign rsp.event_pressed  = ev_pressed_q;
  assign rsp.events_added   = added_q;
  assign rsp.events_dropped = dropped_q;
  assign rsp.queued_count   = qcount_q;

  `KCEQ_ASSERT_ALWAYS(a_count_bound, ring_count <= CNT_W'(QUEUE_DEPTH))
  `KCEQ_ASSERT_ALWAYS(a_drop_le_add, (dropped <= added) && (added <= TALLY_W'(KEY_LIMIT)))
  `KCEQ_ASSERT_NEXT(a_push_grows, ring_cmd.push && !ring_stat.full,
                    ring_count == $past(ring_count) + 1'b1)
  `KCEQ_ASSERT_NEXT(a_pop_hit, ring_cmd.pop, (st == ST_FIN) && pop_hit)
  `KCEQ_ASSERT_NEXT(a_clear_empty, ring_cmd.clear, ring_stat.empty && (st == ST_FIN))

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for key_change_event_queue_top: directed and random command items,
// each result checked against a shadow of the event ring kept in a scoreboard class.
// Depends on kceq_pkg, kceq_in_if and kceq_out_if.
module tb_top import kceq_pkg::*; ();

  localparam int RING_DEPTH = 64;
  localparam int KEY_LANES  = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;  // decodes to no operation
  localparam int ERR_SHOWN  = 10;
  localparam int HOLD_AFTER = 500;   // results seen before the long receiver hold
  localparam int HOLD_LEN   = 250;
  localparam int DRAIN_WAIT = 24;    // a little over the sample latency
  localparam int SEG_COUNT  = 20;
  localparam int SEG_ITEMS  = 70;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} cmd_mix_t;

  typedef struct packed {
    logic               event_valid;
    logic [KEY_W-1:0]   event_key;
    logic               event_pressed;
    logic [TALLY_W-1:0] events_added;
    logic [TALLY_W-1:0] events_dropped;
    logic [QCNT_W-1:0]  queued_count;
  } event_result_t;

  class key_event_ledger;
    logic [ENTRY_W-1:0] ring_shadow [RING_DEPTH];
    int                 head_idx;
    int                 held_count;
    logic [KEY_IN_W-1:0] prev_keys;
    event_result_t      expected_results [$];
    int                 error_count;

    function new();
      head_idx    = 0;
      held_count  = 0;
      prev_keys   = '0;
      error_count = 0;
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_IN_W-1:0] keys);
      event_result_t       r;
      logic [KEY_IN_W-1:0] changed;
      r = '0;
      case (cmd)
        CMD_SAMPLE: begin
          changed = keys ^ prev_keys;
          for (int i = 0; i < KEY_LANES; i++) begin
            if (changed[i]) begin
              if (held_count >= RING_DEPTH) begin
                // full: the oldest event makes room
                head_idx = (head_idx + 1) % RING_DEPTH;
                held_count--;
                r.events_dropped = r.events_dropped + 1'b1;
              end
              ring_shadow[(head_idx + held_count) % RING_DEPTH] = {keys[i], KEY_W'(i)};
              held_count++;
              r.events_added = r.events_added + 1'b1;
            end
          end
          prev_keys = keys;
        end
        CMD_POP: begin
          if (held_count > 0) begin
            r.event_valid   = 1'b1;
            r.event_key     = ring_shadow[head_idx][KEY_W-1:0];
            r.event_pressed = ring_shadow[head_idx][KEY_W];
            head_idx = (head_idx + 1) % RING_DEPTH;
            held_count--;
          end
        end
        CMD_RESTART: begin
          head_idx   = 0;
          held_count = 0;
          prev_keys  = keys;
        end
        default: ;
      endcase
      r.queued_count = QCNT_W'(held_count);
      expected_results.push_back(r);
    endfunction

    function void check_result(event_result_t got);
      event_result_t want;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= ERR_SHOWN)
          $display("%0t: result with nothing outstanding: %p", $realtime, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.event_valid !== want.event_valid || got.event_key !== want.event_key ||
          got.event_pressed !== want.event_pressed ||
          got.events_added !== want.events_added ||
          got.events_dropped !== want.events_dropped ||
          got.queued_count !== want.queued_count) begin
        error_count++;
        if (error_count <= ERR_SHOWN) begin
          $display("%0t: mismatch exp valid=%0d key=%0d pressed=%0d added=%0d dropped=%0d cnt=%0d",
                   $realtime, want.event_valid, want.event_key, want.event_pressed,
                   want.events_added, want.events_dropped, want.queued_count);
          $display("%0t:          got valid=%0d key=%0d pressed=%0d added=%0d dropped=%0d cnt=%0d",
                   $realtime, got.event_valid, got.event_key, got.event_pressed,
                   got.events_added, got.events_dropped, got.queued_count);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  kceq_in_if  in_ch ();
  kceq_out_if out_ch ();

  key_change_event_queue_top DUT (
    .clk (clk),
    .rst (rst),
    .req (in_ch),
    .rsp (out_ch)
  );

  key_event_ledger     ledger = new();
  logic                burst_mode = 1'b0;   // no idling on either side while set
  int                  results_seen = 0;
  logic [KEY_IN_W-1:0] last_sent_keys = '0;
  event_result_t       seen;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic logic [KEY_IN_W-1:0] vary_keys(logic [KEY_IN_W-1:0] prev);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return KEY_IN_W'($urandom);
    if (pick < 55) return prev ^ (KEY_IN_W'(1) << $urandom_range(0, KEY_LANES - 1));
    if (pick < 75) return prev ^ (KEY_IN_W'($urandom) & KEY_IN_W'($urandom));
    if (pick < 85) return ~prev;
    return prev;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_IN_W-1:0] keys);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.key_bits <= keys;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.note_command(cmd, keys);
    if (cmd == CMD_SAMPLE || cmd == CMD_RESTART) last_sent_keys = keys;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_segment(input int count, input cmd_mix_t mix);
    int roll;
    int sample_cut;
    int pop_cut;
    int restart_cut;
    case (mix)
      MIX_FILL:  begin sample_cut = 75; pop_cut = 95; restart_cut = 97; end
      MIX_DRAIN: begin sample_cut = 12; pop_cut = 97; restart_cut = 98; end
      default:   begin sample_cut = 50; pop_cut = 92; restart_cut = 96; end
    endcase
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < sample_cut)       send_item(CMD_SAMPLE, vary_keys(last_sent_keys));
      else if (roll < pop_cut)     send_item(CMD_POP, KEY_IN_W'($urandom));
      else if (roll < restart_cut) send_item(CMD_RESTART, KEY_IN_W'($urandom));
      else                         send_item(CMD_UNUSED, KEY_IN_W'($urandom));
    end
  endtask

  // Result side: random stalls plus one long hold so the block backs up.
  initial begin
    int  stall;
    bit  hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.event_valid    = out_ch.event_valid;
      seen.event_key      = out_ch.event_key;
      seen.event_pressed  = out_ch.event_pressed;
      seen.events_added   = out_ch.events_added;
      seen.events_dropped = out_ch.events_dropped;
      seen.queued_count   = out_ch.queued_count;
      results_seen++;
      ledger.check_result(seen);
    end
  end

  initial begin
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_SAMPLE;
    in_ch.key_bits <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pops, no-change sample, full flips, ring overflow, restart.
    send_item(CMD_POP,     16'h0000);
    send_item(CMD_SAMPLE,  16'h0000);
    send_item(CMD_SAMPLE,  16'hFFFF);
    send_item(CMD_POP,     16'h0000);
    send_item(CMD_POP,     16'hFFFF);
    send_item(CMD_SAMPLE,  16'h0000);
    send_item(CMD_UNUSED,  16'hFFFF);
    send_item(CMD_SAMPLE,  16'hFFFF);
    send_item(CMD_SAMPLE,  16'h0000);
    send_item(CMD_SAMPLE,  16'h8001);   // fills the ring exactly
    send_item(CMD_SAMPLE,  16'h0001);   // one drop
    send_item(CMD_SAMPLE,  16'hFFFF);
    send_item(CMD_SAMPLE,  16'h0000);   // sixteen drops
    send_item(CMD_RESTART, 16'hA5A5);
    send_item(CMD_POP,     16'h0000);
    send_item(CMD_SAMPLE,  16'hA5A5);
    send_item(CMD_SAMPLE,  16'h5A5A);
    send_item(CMD_POP,     16'h0000);
    send_item(CMD_RESTART, 16'h0000);
    send_item(CMD_SAMPLE,  16'h0001);
    send_item(CMD_POP,     16'h0000);
    send_item(CMD_POP,     16'h0000);
    send_item(CMD_UNUSED,  16'h0000);

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      burst_mode = (seg % 4 == 3);
      run_segment(SEG_ITEMS, cmd_mix_t'($urandom_range(0, 2)));
    end
    burst_mode = 1'b0;
    in_ch.valid <= 1'b0;

    while (ledger.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (ledger.error_count == 0 && ledger.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/kceq_pkg.sv
src/kceq_in_if.sv
src/kceq_out_if.sv
src/kceq_scan.sv
src/kceq_ring.sv
src/key_change_event_queue_top.sv
dv/tb_top.sv
